@@ rtl/lurt_pkg.sv @@
// Package for the longest unique run tracker.
// Widths, depth and length bound; no dependencies.
package lurt_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned SYM_NUM = 1 << SYM_W;
  localparam int unsigned LEN_W   = 16;

  // string length bound, capped to what a 16-bit position can count
  localparam longint unsigned MAX_LEN   = 64'd65535;
  localparam longint unsigned LEN_CAP   = (64'd1 << LEN_W) - 64'd1;
  localparam longint unsigned POS_LIMIT = (MAX_LEN > LEN_CAP) ? LEN_CAP : MAX_LEN;
  localparam logic [LEN_W-1:0] POS_LIMIT_V = POS_LIMIT[LEN_W-1:0];

endpackage

@@ rtl/lurt_if.sv @@
// Handshake channel interfaces for the input byte and the result word.
// Depends on lurt_pkg for field widths.
interface lurt_in_if;
  logic                          valid;
  logic                          ready;
  logic [lurt_pkg::SYM_W-1:0]    symbol;
  logic                          first;

  modport source (output valid, output symbol, output first, input ready);
  modport sink   (input valid, input symbol, input first, output ready);
endinterface

interface lurt_out_if;
  logic                          valid;
  logic                          ready;
  logic [lurt_pkg::LEN_W-1:0]    window_length;
  logic [lurt_pkg::LEN_W-1:0]    best_length;
  logic                          overflow;

  modport source (output valid, output window_length, output best_length,
                  output overflow, input ready);
  modport sink   (input valid, input window_length, input best_length,
                  input overflow, output ready);
endinterface

@@ rtl/lurt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on lurt_pkg for default sizes.
module lurt_ram #(
  parameter int unsigned WIDTH = lurt_pkg::LEN_W,
  parameter int unsigned DEPTH = lurt_pkg::SYM_NUM,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/longest_unique_run_tracker_top.sv @@
// Top level of the longest unique run tracker.
// Depends on lurt_pkg, lurt_if (channels) and lurt_ram (last-position table).
//
//  channel | dir | word                                        | handshake
//  --------+-----+---------------------------------------------+------------
//  in_ch   | in  | symbol[7:0], first                          | valid/ready
//  out_ch  | out | window_length[15:0], best_length[15:0],     | valid/ready
//          |     | overflow                                    |
//
// One word per cycle unless out_ch stalls. Stage 1 reads the last-position
// RAM on input accept; stage 2 (holding register) does the read-modify-write
// and loads the output register, which drives out_ch.valid.
// Reset (rst_n low, synchronous) clears the seen flags, counters and both
// pipeline valids; no clearing pass is needed, seen flags are flip-flops.
// A stalled output holds stage 2, which then drops in_ch.ready.
module longest_unique_run_tracker_top (
  input  logic          clk,
  input  logic          rst_n,
  lurt_in_if.sink       in_ch,
  lurt_out_if.source    out_ch
);

  localparam int unsigned SYM_W   = lurt_pkg::SYM_W;
  localparam int unsigned SYM_NUM = lurt_pkg::SYM_NUM;
  localparam int unsigned LEN_W   = lurt_pkg::LEN_W;

  // stage 2 holding register: word whose RAM read is in flight/complete
  logic             s1_valid_r, s1_valid_nxt;
  logic [SYM_W-1:0] s1_sym_r;
  logic             s1_first_r;

  // per-string scalar state
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] ws_r, ws_nxt;
  logic [LEN_W-1:0] best_r, best_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SYM_NUM-1:0] seen_valid_r, seen_valid_nxt;

  // most recent table write, forwarded over the RAM read
  logic             wr_valid_r, wr_valid_nxt;
  logic [SYM_W-1:0] wr_sym_r;
  logic [LEN_W-1:0] wr_pos_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] out_win_r, out_win_nxt;
  logic [LEN_W-1:0] out_best_r, out_best_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             in_acc;
  logic             s1_proc;
  logic             ram_we;
  logic [LEN_W-1:0] ram_rdata;
  logic [LEN_W-1:0] last_pos;
  logic [LEN_W-1:0] cur_pos, cur_ws, cur_best;
  logic             cur_ovf;
  logic             seen;

  lurt_ram #(
    .WIDTH (LEN_W),
    .DEPTH (SYM_NUM)
  ) u_last_pos (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_sym_r),
    .wdata (cur_pos),
    .re    (in_acc),
    .raddr (in_ch.symbol),
    .rdata (ram_rdata)
  );

  always_comb begin
    // stage 2 advances whenever the output register is free or draining
    s1_proc     = s1_valid_r && (!out_valid_r || out_ch.ready);
    in_ch.ready = !s1_valid_r || s1_proc;
    in_acc      = in_ch.valid && in_ch.ready;

    // a first byte sees a freshly cleared string
    cur_pos  = s1_first_r ? '0 : pos_r;
    cur_ws   = s1_first_r ? '0 : ws_r;
    cur_best = s1_first_r ? '0 : best_r;
    cur_ovf  = s1_first_r ? 1'b0 : ovf_r;
    seen     = !s1_first_r && seen_valid_r[s1_sym_r];
    last_pos = (wr_valid_r && (wr_sym_r == s1_sym_r)) ? wr_pos_r : ram_rdata;

    s1_valid_nxt   = in_acc ? 1'b1 : (s1_proc ? 1'b0 : s1_valid_r);
    pos_nxt        = pos_r;
    ws_nxt         = ws_r;
    best_nxt       = best_r;
    ovf_nxt        = ovf_r;
    seen_valid_nxt = seen_valid_r;
    wr_valid_nxt   = wr_valid_r;
    ram_we         = 1'b0;
    out_win_nxt    = out_win_r;
    out_best_nxt   = out_best_r;
    out_ovf_nxt    = out_ovf_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;

    if (s1_proc) begin
      out_valid_nxt = 1'b1;
      if (cur_pos >= lurt_pkg::POS_LIMIT_V) begin
        // string full: byte dropped, window saturates at the last taken byte
        pos_nxt      = cur_pos;
        ws_nxt       = cur_ws;
        best_nxt     = cur_best;
        ovf_nxt      = 1'b1;
        out_win_nxt  = cur_pos - cur_ws;
        out_best_nxt = cur_best;
        out_ovf_nxt  = 1'b1;
        if (s1_first_r) begin
          seen_valid_nxt = '0;
        end
      end else begin
        // jump the window start past an earlier copy inside the window
        if (seen && (last_pos >= cur_ws)) begin
          ws_nxt = last_pos + LEN_W'(1);
        end else begin
          ws_nxt = cur_ws;
        end
        out_win_nxt  = cur_pos - ws_nxt + LEN_W'(1);
        best_nxt     = (out_win_nxt > cur_best) ? out_win_nxt : cur_best;
        out_best_nxt = best_nxt;
        ovf_nxt      = cur_ovf;
        out_ovf_nxt  = cur_ovf;
        pos_nxt      = cur_pos + LEN_W'(1);
        ram_we       = 1'b1;
        wr_valid_nxt = 1'b1;
        if (s1_first_r) begin
          seen_valid_nxt = '0;
        end
        seen_valid_nxt[s1_sym_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pos_r        <= '0;
      ws_r         <= '0;
      best_r       <= '0;
      ovf_r        <= 1'b0;
      seen_valid_r <= '0;
      wr_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      pos_r        <= pos_nxt;
      ws_r         <= ws_nxt;
      best_r       <= best_nxt;
      ovf_r        <= ovf_nxt;
      seen_valid_r <= seen_valid_nxt;
      wr_valid_r   <= wr_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r   <= in_ch.symbol;
      s1_first_r <= in_ch.first;
    end
    if (ram_we) begin
      wr_sym_r <= s1_sym_r;
      wr_pos_r <= cur_pos;
    end
    out_win_r  <= out_win_nxt;
    out_best_r <= out_best_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.window_length = out_win_r;
  assign out_ch.best_length   = out_best_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

@@ rtl/lurt_checker.sv @@
// Port-level assertions for the longest unique run tracker, and their bind.
// Depends on lurt_pkg for widths; attaches to longest_unique_run_tracker_top.
module lurt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lurt_pkg::LEN_W-1:0] window_length,
  input logic [lurt_pkg::LEN_W-1:0] best_length,
  input logic                       overflow
);

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without output stall");

  // a run always holds the current byte, and best covers it
  a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((window_length != '0) && (best_length >= window_length)))
    else $error("window/best length out of order");

  // an accepted input with no result pending is answered by a result when unstalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) ##1 out_ready |=> out_valid)
    else $error("result missing after accepted word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(window_length)
      && $stable(best_length) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind longest_unique_run_tracker_top lurt_checker u_lurt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .window_length (out_ch.window_length),
  .best_length   (out_ch.best_length),
  .overflow      (out_ch.overflow)
);
